[rtl/srmc_pkg.sv]
// Shared types, codes and constants of the stepper ramp motion controller.
package srmc_pkg;

	// Count width of the step and ramp counters (default of the top-level parameter)
	localparam int COUNT_WIDTH_DEF = 24;

	// Field widths
	localparam int KIND_W   = 2;
	localparam int STEPS_W  = 24;
	localparam int SPEED_W  = 16;
	localparam int PERIOD_W = 16;
	localparam int CLOCK_W  = 24;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 32;

	// Stream beat widths
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 56;

	// Configuration port widths
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	// Divider iterations: one quotient bit per cycle over the dividend
	localparam int DIV_STEPS = CLOCK_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [PERIOD_W-1:0] PERIOD_TOP = 16'hffff;
	localparam logic [SPEED_W-1:0]  SPEED_TOP  = 16'hffff;

	// Register reset values
	localparam logic [SPEED_W-1:0]  SPD_FLOOR_RST   = 16'd100;
	localparam logic [SPEED_W-1:0]  SPD_CEIL_RST    = 16'd2000;
	localparam logic [PERIOD_W-1:0] PERIOD_SLOW_RST = 16'd0;
	localparam logic [PERIOD_W-1:0] PERIOD_FAST_RST = 16'd65000;
	localparam logic [CLOCK_W-1:0]  TICK_CLOCK_RST  = 24'd250000;

	typedef enum logic [KIND_W-1:0] {
		KIND_START = 2'd0,
		KIND_STEP  = 2'd1,
		KIND_RAMP  = 2'd2,
		KIND_STOP  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE   = 3'd0,
		STAT_LEFT   = 3'd1,
		STAT_RIGHT  = 3'd2,
		STAT_BRAKE  = 3'd3,
		STAT_MOVING = 3'd4
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SPD_FLOOR   = 3'd0,
		REG_SPD_CEIL    = 3'd1,
		REG_PERIOD_SLOW = 3'd2,
		REG_PERIOD_FAST = 3'd3,
		REG_TICK_CLOCK  = 3'd4
	} cfg_reg_t;

	// Divider handshake toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

[rtl/srmc_div.sv]
// Restoring divider: tick clock over a 16-bit divisor, one quotient bit per cycle.
module srmc_div
	import srmc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CLOCK_W-1:0]  dividend,
	input  logic [SPEED_W-1:0]  divisor,
	output div_status_t         status,
	output logic [CLOCK_W-1:0]  quotient
);

	logic [CLOCK_W-1:0]   dvd_q;     // dividend shifts out, quotient shifts in
	logic [SPEED_W-1:0]   rem_q;
	logic [SPEED_W-1:0]   div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [SPEED_W:0] rem_sh;
	logic [SPEED_W:0] diff;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q, dvd_q[CLOCK_W-1]};
		ge     = rem_sh >= {1'b0, div_q};
		diff   = rem_sh - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
					busy_q <= 1'b0;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SPEED_W-1:0] : rem_sh[SPEED_W-1:0];
			dvd_q <= {dvd_q[CLOCK_W-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = dvd_q;

endmodule

[rtl/stepper_ramp_motion_controller_core.sv]
// Top level of the stepper ramp motion controller: event sequencer, state and stream ports.
//
// Each input beat is one event (start, step tick, ramp tick, stop request) and yields exactly
// one result beat with the step pulse, the timer reload, the motion status, the position and
// the run and driver flags. A step tick, a stop request or any tick while halted goes from
// acceptance to ST_OUT, which loads the result register once it is free. A start or a ramp
// tick evaluates the timer reload; when the speed lies between the floor and ceiling speed
// registers this runs the shared restoring divider (tick_clock over speed). A ramp tick that
// applies a pending stop also runs the divider, unless the period is all ones, to recover
// the speed from the period. The divider is the only arithmetic unit of weight. s_tready is
// high only while the sequencer is idle; a finished result waits in the output register and
// does not block acceptance of the next beat. Configuration writes are always taken and must
// be issued only while the block is idle.
module stepper_ramp_motion_controller_core
	import srmc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,

	// Input events
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [IN_DATA_W-1:0]    s_tdata,   // move_steps[23:0], direction[24],
	                                           // ramp_steps[48:25], left_switch_hit[49],
	                                           // right_switch_hit[50], zero fill
	input  logic [KIND_W-1:0]       s_tuser,   // kind[1:0]

	// Results
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_DATA_W-1:0]   m_tdata,   // step_pulse[0], timer_reload[16:1],
	                                           // motion_status[19:17], position[51:20],
	                                           // moving[52], driver_disable[53], zero fill

	// Configuration writes
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int RAMP_W = COUNT_WIDTH + 1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_RELOAD = 6'b000010,   // pick the reload, start the divider if needed
		ST_DIV1   = 6'b000100,   // wait for tick_clock / speed
		ST_STOP   = 6'b001000,   // apply a pending stop
		ST_DIV2   = 6'b010000,   // wait for tick_clock / (0xffff - period)
		ST_OUT    = 6'b100000    // hand the result to the output register
	} seq_state_t;

	seq_state_t state_q;

	// Configuration registers
	logic [SPEED_W-1:0]  spd_floor_q;
	logic [SPEED_W-1:0]  spd_ceil_q;
	logic [PERIOD_W-1:0] period_slow_q;
	logic [PERIOD_W-1:0] period_fast_q;
	logic [CLOCK_W-1:0]  tick_clock_q;

	// Motion state
	logic [POS_W-1:0]        coord_q;
	logic [COUNT_WIDTH-1:0]  steps_left_q;
	logic signed [RAMP_W-1:0] ramp_left_q;
	logic [SPEED_W-1:0]      speed_q;
	logic [PERIOD_W-1:0]     period_q;
	status_t                 status_q;
	logic                    stop_pend_q;
	logic                    running_q;
	logic                    dir_q;
	logic                    drive_off_q;
	logic                    pulse_q;

	// Unpacked input beat
	kind_t                   in_kind;
	logic [STEPS_W-1:0]      in_move;
	logic                    in_dir;
	logic [STEPS_W-1:0]      in_ramp;
	logic                    in_lhit;
	logic                    in_rhit;
	logic [31:0]             move_ext;
	logic [31:0]             ramp_ext;

	logic                    in_fire;
	logic                    out_free;
	logic                    step_go;

	// Divider
	logic                    div_start;
	logic [SPEED_W-1:0]      div_divisor;
	div_status_t             div_stat;
	logic [CLOCK_W-1:0]      div_quot;

	logic [SPEED_W-1:0]      stop_divisor;
	logic [SPEED_W-1:0]      ramp_speed;
	logic                    ramp_pos;
	logic signed [RAMP_W-1:0] ramp_floor;

	assign in_kind  = kind_t'(s_tuser);
	assign in_move  = s_tdata[23:0];
	assign in_dir   = s_tdata[24];
	assign in_ramp  = s_tdata[48:25];
	assign in_lhit  = s_tdata[49];
	assign in_rhit  = s_tdata[50];
	// Keep the low COUNT_WIDTH bits of each count, zero-extended when wider
	assign move_ext = {8'd0, in_move};
	assign ramp_ext = {8'd0, in_ramp};

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign cfg_ready = 1'b1;

	// A running step tick issues a step unless a switch, the count or braking halts it
	assign step_go = running_q && !(in_lhit && !dir_q) && !(in_rhit && dir_q) &&
	                 (steps_left_q != '0) &&
	                 !(status_q == STAT_BRAKE && speed_q <= spd_floor_q);

	assign stop_divisor = PERIOD_TOP - period_q;
	assign ramp_floor   = {1'b1, {COUNT_WIDTH{1'b0}}};
	assign ramp_pos     = !ramp_left_q[RAMP_W-1] && (ramp_left_q != '0);

	// Ramp tick speed: accelerate while ramp steps remain, else decelerate; saturate
	always_comb begin
		ramp_speed = speed_q;
		if (ramp_pos) begin
			if (speed_q != SPEED_TOP) ramp_speed = speed_q + 1'b1;
		end else begin
			if (speed_q != '0) ramp_speed = speed_q - 1'b1;
		end
	end

	always_comb begin
		div_start   = 1'b0;
		div_divisor = speed_q;
		case (state_q)
			ST_RELOAD: begin
				div_start = (speed_q >= spd_floor_q) && (speed_q < spd_ceil_q) &&
				            (speed_q != '0);
			end
			ST_STOP: begin
				div_divisor = stop_divisor;
				div_start   = (stop_divisor != '0);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	srmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tick_clock_q),
		.divisor  (div_divisor),
		.status   (div_stat),
		.quotient (div_quot)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_floor_q   <= SPD_FLOOR_RST;
			spd_ceil_q    <= SPD_CEIL_RST;
			period_slow_q <= PERIOD_SLOW_RST;
			period_fast_q <= PERIOD_FAST_RST;
			tick_clock_q  <= TICK_CLOCK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SPD_FLOOR:   spd_floor_q   <= cfg_data[SPEED_W-1:0];
				REG_SPD_CEIL:    spd_ceil_q    <= cfg_data[SPEED_W-1:0];
				REG_PERIOD_SLOW: period_slow_q <= cfg_data[PERIOD_W-1:0];
				REG_PERIOD_FAST: period_fast_q <= cfg_data[PERIOD_W-1:0];
				REG_TICK_CLOCK:  tick_clock_q  <= cfg_data[CLOCK_W-1:0];
				default: ;
			endcase
		end
	end

	// Output valid: raise when a beat is loaded, drop once it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Sequencer and motion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			coord_q      <= '0;
			steps_left_q <= '0;
			ramp_left_q  <= '0;
			speed_q      <= '0;
			period_q     <= '0;
			status_q     <= STAT_DONE;
			stop_pend_q  <= 1'b0;
			running_q    <= 1'b0;
			dir_q        <= 1'b0;
			drive_off_q  <= 1'b1;
			pulse_q      <= 1'b0;
			m_tdata      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						pulse_q <= (in_kind == KIND_STEP) && step_go;
						case (in_kind)
							KIND_START: begin
								steps_left_q <= move_ext[COUNT_WIDTH-1:0];
								ramp_left_q  <= $signed({1'b0, ramp_ext[COUNT_WIDTH-1:0]});
								dir_q        <= in_dir;
								speed_q      <= spd_floor_q;
								status_q     <= STAT_MOVING;
								stop_pend_q  <= 1'b0;
								running_q    <= 1'b1;
								drive_off_q  <= 1'b0;
								state_q      <= ST_RELOAD;
							end
							KIND_STEP: begin
								state_q <= ST_OUT;
								if (running_q) begin
									if (in_lhit && !dir_q) begin
										status_q  <= STAT_LEFT;
										running_q <= 1'b0;
									end else if (in_rhit && dir_q) begin
										status_q  <= STAT_RIGHT;
										running_q <= 1'b0;
									end else if (steps_left_q == '0 ||
									             (status_q == STAT_BRAKE &&
									              speed_q <= spd_floor_q)) begin
										// Normal completion: disable the driver
										status_q    <= STAT_DONE;
										running_q   <= 1'b0;
										drive_off_q <= 1'b1;
									end else begin
										coord_q      <= dir_q ? coord_q + 1'b1 : coord_q - 1'b1;
										steps_left_q <= steps_left_q - 1'b1;
										if (ramp_left_q != ramp_floor)
											ramp_left_q <= ramp_left_q - 1'b1;
									end
								end
							end
							KIND_RAMP: begin
								if (running_q) begin
									speed_q <= ramp_speed;
									state_q <= ST_RELOAD;
								end else begin
									state_q <= ST_OUT;
								end
							end
							KIND_STOP: begin
								state_q <= ST_OUT;
								if (running_q) stop_pend_q <= 1'b1;
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_RELOAD: begin
					// Clamp the reload at both ends, else divide
					if (speed_q < spd_floor_q) begin
						period_q <= period_slow_q;
						state_q  <= stop_pend_q ? ST_STOP : ST_OUT;
					end else if (speed_q >= spd_ceil_q) begin
						period_q <= period_fast_q;
						state_q  <= stop_pend_q ? ST_STOP : ST_OUT;
					end else if (speed_q == '0) begin
						period_q <= '0;
						state_q  <= stop_pend_q ? ST_STOP : ST_OUT;
					end else begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_stat.done) begin
						if (div_quot[CLOCK_W-1:PERIOD_W] != '0)
							period_q <= '0;
						else
							period_q <= PERIOD_TOP - div_quot[PERIOD_W-1:0];
						state_q <= stop_pend_q ? ST_STOP : ST_OUT;
					end
				end
				ST_STOP: begin
					// Turn the motion into braking from the current period
					ramp_left_q <= '0;
					stop_pend_q <= 1'b0;
					status_q    <= STAT_BRAKE;
					if (stop_divisor == '0) begin
						speed_q <= spd_ceil_q;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_stat.done) begin
						// Saturate the quotient, then cap it at the ceiling speed
						if (div_quot[CLOCK_W-1:SPEED_W] != '0 ||
						    div_quot[SPEED_W-1:0] >= spd_ceil_q)
							speed_q <= (spd_ceil_q <= SPEED_TOP) ? spd_ceil_q : SPEED_TOP;
						else
							speed_q <= div_quot[SPEED_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// Hold until the output register is free, then load the beat
					if (out_free) begin
						m_tdata  <= {2'b00, drive_off_q, running_q, coord_q,
						             status_q, period_q, pulse_q};
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[test/srmc_motion_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the stepper ramp motion controller: tracks motion state and checks result beats.
module srmc_motion_checker
	import srmc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,
	input  logic [KIND_W-1:0]      s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_DATA_W-1:0]  m_tdata,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     results_owed,
	output logic                   motion_active
);

	typedef struct {
		logic                step_pulse;
		logic [PERIOD_W-1:0] timer_reload;
		status_t             motion_status;
		logic [POS_W-1:0]    position;
		logic                moving;
		logic                driver_disable;
	} motion_report_t;

	motion_report_t owed_reports[$];

	// Register copies
	logic [SPEED_W-1:0]  spd_lo, spd_hi;
	logic [PERIOD_W-1:0] per_slow, per_fast;
	logic [CLOCK_W-1:0]  clk_rate;

	// Motion state
	logic [POS_W-1:0]    pos;
	logic [STEPS_W-1:0]  steps_rem;
	longint              ramp_rem;
	int unsigned         cur_speed;
	logic [PERIOD_W-1:0] cur_period;
	status_t             cur_status;
	bit                  stop_req, run, dir_right, drv_off;

	assign motion_active = run;

	function automatic logic [PERIOD_W-1:0] reload_of(input int unsigned s);
		int unsigned q;
		if (s < spd_lo) return per_slow;
		if (s >= spd_hi) return per_fast;
		if (s == 0) return '0;
		q = clk_rate / s;
		if (q > 32'hffff) return '0;
		return PERIOD_W'(32'hffff - q);
	endfunction

	task automatic halt_motion(input status_t code, input bit disable_drive);
		cur_status = code;
		run = 1'b0;
		if (disable_drive) drv_off = 1'b1;
	endtask

	task automatic apply_event(input kind_t k, input logic [STEPS_W-1:0] mv, input logic d,
			input logic [STEPS_W-1:0] rs, input logic lh, input logic rh,
			output motion_report_t rep);
		bit pulse;
		int unsigned divisor, q;
		pulse = 1'b0;
		case (k)
			KIND_START: begin
				steps_rem = mv;
				dir_right = d;
				ramp_rem = longint'(rs);
				cur_speed = spd_lo;
				cur_period = reload_of(cur_speed);
				cur_status = STAT_MOVING;
				stop_req = 1'b0;
				run = 1'b1;
				drv_off = 1'b0;
			end
			KIND_STEP: if (run) begin
				if (lh && !dir_right) halt_motion(STAT_LEFT, 1'b0);
				else if (rh && dir_right) halt_motion(STAT_RIGHT, 1'b0);
				else if (steps_rem == 0) halt_motion(STAT_DONE, 1'b1);
				else if (cur_status == STAT_BRAKE && cur_speed <= spd_lo)
					halt_motion(STAT_DONE, 1'b1);
				else begin
					pos = dir_right ? pos + 1'b1 : pos - 1'b1;
					steps_rem = steps_rem - 1'b1;
					if (ramp_rem > -(longint'(1) << COUNT_WIDTH_DEF)) ramp_rem--;
					pulse = 1'b1;
				end
			end
			KIND_RAMP: if (run) begin
				if (ramp_rem > 0) begin
					if (cur_speed < 32'hffff) cur_speed++;
				end else if (cur_speed > 0) begin
					cur_speed--;
				end
				cur_period = reload_of(cur_speed);
				// pending stop: recover speed from the period and brake from there
				if (stop_req) begin
					divisor = 32'hffff - cur_period;
					if (divisor == 0) begin
						cur_speed = spd_hi;
					end else begin
						q = clk_rate / divisor;
						if (q > 32'hffff) q = 32'hffff;
						cur_speed = q;
					end
					if (cur_speed >= spd_hi) cur_speed = spd_hi;
					ramp_rem = 0;
					stop_req = 1'b0;
					cur_status = STAT_BRAKE;
				end
			end
			KIND_STOP: if (run) stop_req = 1'b1;
			default: ;
		endcase
		rep.step_pulse = pulse;
		rep.timer_reload = cur_period;
		rep.motion_status = cur_status;
		rep.position = pos;
		rep.moving = run;
		rep.driver_disable = drv_off;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		motion_report_t got, want;
		if (!arst_n) begin
			spd_lo = SPD_FLOOR_RST;
			spd_hi = SPD_CEIL_RST;
			per_slow = PERIOD_SLOW_RST;
			per_fast = PERIOD_FAST_RST;
			clk_rate = TICK_CLOCK_RST;
			pos = '0;
			steps_rem = '0;
			ramp_rem = 0;
			cur_speed = 0;
			cur_period = '0;
			cur_status = STAT_DONE;
			stop_req = 1'b0;
			run = 1'b0;
			dir_right = 1'b0;
			drv_off = 1'b1;
			owed_reports.delete();
			results_owed = 0;
			fail_count = 0;
		end else begin
			// retire the result first: it always belongs to an earlier beat
			if (m_tvalid && m_tready) begin
				got.step_pulse = m_tdata[0];
				got.timer_reload = m_tdata[16:1];
				got.motion_status = status_t'(m_tdata[19:17]);
				got.position = m_tdata[51:20];
				got.moving = m_tdata[52];
				got.driver_disable = m_tdata[53];
				if (owed_reports.size() == 0) begin
					$error("result beat with no expectation waiting");
					fail_count++;
				end else begin
					want = owed_reports.pop_front();
					if (got.step_pulse !== want.step_pulse) begin
						$error("step_pulse: expected %0d, actual %0d",
							want.step_pulse, got.step_pulse);
						fail_count++;
					end
					if (got.timer_reload !== want.timer_reload) begin
						$error("timer_reload: expected %0d, actual %0d",
							want.timer_reload, got.timer_reload);
						fail_count++;
					end
					if (got.motion_status !== want.motion_status) begin
						$error("motion_status: expected %0d, actual %0d",
							want.motion_status, got.motion_status);
						fail_count++;
					end
					if (got.position !== want.position) begin
						$error("position: expected %0d, actual %0d",
							$signed(want.position), $signed(got.position));
						fail_count++;
					end
					if (got.moving !== want.moving) begin
						$error("moving: expected %0d, actual %0d", want.moving, got.moving);
						fail_count++;
					end
					if (got.driver_disable !== want.driver_disable) begin
						$error("driver_disable: expected %0d, actual %0d",
							want.driver_disable, got.driver_disable);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_SPD_FLOOR:   spd_lo = cfg_data[SPEED_W-1:0];
					REG_SPD_CEIL:    spd_hi = cfg_data[SPEED_W-1:0];
					REG_PERIOD_SLOW: per_slow = cfg_data[PERIOD_W-1:0];
					REG_PERIOD_FAST: per_fast = cfg_data[PERIOD_W-1:0];
					REG_TICK_CLOCK:  clk_rate = cfg_data[CLOCK_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				apply_event(kind_t'(s_tuser), s_tdata[23:0], s_tdata[24], s_tdata[48:25],
					s_tdata[49], s_tdata[50], want);
				owed_reports.push_back(want);
			end
			results_owed = owed_reports.size();
		end
	end

endmodule

[test/stepper_ramp_motion_controller_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the stepper ramp motion controller: clock, reset, stimulus and verdict.
module stepper_ramp_motion_controller_core_tb;
	import srmc_pkg::*;

	// Longest item is a ramp tick that applies a stop: two divider passes
	localparam int DRAIN_CYCLES = 64;
	// Long receiver hold-off that backs results up into the input side
	localparam int CHOKE_CYCLES = 400;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;     // move_steps, direction, ramp_steps, left, right
	logic [KIND_W-1:0]      s_tuser = KIND_START;  // kind
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;          // pulse, reload, status, position, moving, disable
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SPD_FLOOR;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int   fail_count;
	int   results_owed;
	logic motion_active;

	// Shared between stimulus and the receiver process
	bit   calm = 1'b0;
	int   chokes_asked = 0;

	stepper_ramp_motion_controller_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	srmc_motion_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.results_owed  (results_owed),
		.motion_active (motion_active)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("stepper_ramp_motion_controller_core_tb failed");
		$finish;
	end

	// Result receiver: random back-pressure bursts, plus one long choke on request.
	// Exactly one assignment to m_tready per falling edge.
	initial begin
		int choke_left;
		int burst_left;
		int chokes_done;
		choke_left = 0;
		burst_left = 0;
		chokes_done = 0;
		forever begin
			@(negedge clk);
			if (choke_left == 0 && chokes_done != chokes_asked) begin
				chokes_done++;
				choke_left = CHOKE_CYCLES;
			end
			if (choke_left > 0) begin
				choke_left--;
				m_tready <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 16) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one event beat. Enter at any point; start at the next falling edge, optionally
	// idle for a burst, then hold the beat until it is taken. Valid stays high on return so
	// a back-to-back beat never drops it within one time step.
	task automatic offer_event(input kind_t k, input logic [STEPS_W-1:0] mv, input logic d,
			input logic [STEPS_W-1:0] rs, input logic lh, input logic rh);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, rh, lh, rs, d, mv};
		s_tuser <= k;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and wait until every beat has its result and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (results_owed == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reprogram all five registers; only ever called with the block idle
	task automatic load_settings(input int lo, input int hi, input int slow, input int fast,
			input int rate);
		settle();
		write_reg(REG_SPD_FLOOR, CFG_DATA_W'(lo));
		write_reg(REG_SPD_CEIL, CFG_DATA_W'(hi));
		write_reg(REG_PERIOD_SLOW, CFG_DATA_W'(slow));
		write_reg(REG_PERIOD_FAST, CFG_DATA_W'(fast));
		write_reg(REG_TICK_CLOCK, CFG_DATA_W'(rate));
	endtask

	// Random moves: mostly a start followed by a mix of step, ramp and stop ticks with
	// small counts, a few full-range operands, and some noise of any kind. Ticks that
	// land on a halted block are ignored by it and do not count toward the target.
	task automatic run_moves(input int target);
		int live;
		int pick;
		kind_t k;
		logic [STEPS_W-1:0] mv, rs;
		logic d, lh, rh;
		live = 0;
		while (live < target) begin
			pick = $urandom_range(0, 9);
			d = 1'($urandom_range(0, 1));
			lh = ($urandom_range(0, 9) == 0);
			rh = ($urandom_range(0, 9) == 0);
			mv = ($urandom_range(0, 7) == 0) ? STEPS_W'($urandom) : STEPS_W'($urandom_range(0, 40));
			rs = ($urandom_range(0, 7) == 0) ? STEPS_W'($urandom) : STEPS_W'($urandom_range(0, 25));
			if (pick == 0) begin
				// noise: any kind, any operands, any switch state
				k = kind_t'($urandom_range(0, 3));
				mv = STEPS_W'($urandom);
				rs = STEPS_W'($urandom);
				lh = 1'($urandom_range(0, 1));
				rh = 1'($urandom_range(0, 1));
			end else if (pick == 1 || !motion_active) begin
				k = KIND_START;
			end else begin
				pick = $urandom_range(0, 19);
				if (pick < 10) k = KIND_STEP;
				else if (pick < 18) k = KIND_RAMP;
				else k = KIND_STOP;
			end
			if (k == KIND_START || motion_active) live++;
			offer_event(k, mv, d, rs, lh, rh);
		end
	endtask

	initial begin
		int i;
		int lo;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings. Ticks while halted are ignored.
		offer_event(KIND_STEP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_RAMP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_STOP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		// Short move right: accelerate, stop, then brake from the recovered speed while stepping
		offer_event(KIND_START, 24'd3, 1'b1, 24'd2, 1'b0, 1'b0);
		offer_event(KIND_RAMP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_STEP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_STOP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_RAMP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_STEP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_RAMP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_STEP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		// Zero-step move halts on the first step tick
		offer_event(KIND_START, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_STEP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		// Left switch stops a left move; the driver stays on
		offer_event(KIND_START, 24'd5, 1'b0, 24'd1, 1'b0, 1'b0);
		offer_event(KIND_STEP, 24'd0, 1'b0, 24'd0, 1'b1, 1'b1);
		// Left switch is ignored on a right move, right switch stops it
		offer_event(KIND_START, 24'd5, 1'b1, 24'd1, 1'b0, 1'b0);
		offer_event(KIND_STEP, 24'd0, 1'b0, 24'd0, 1'b1, 1'b0);
		offer_event(KIND_STEP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b1);
		// Full-range counts, then a restart that clears a pending stop
		offer_event(KIND_START, 24'hffffff, 1'b0, 24'hffffff, 1'b0, 1'b0);
		offer_event(KIND_STEP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_STOP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_START, 24'd2, 1'b1, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_RAMP, 24'd0, 1'b0, 24'd0, 1'b0, 1'b0);
		offer_event(KIND_STEP, 24'd0, 1'b0, 24'd0, 1'b1, 1'b0);

		// Widest band, largest clock: quotient clamps, speed can fall to zero
		load_settings(1, 65535, 0, 65534, 24'hffffff);
		run_moves(100);
		// Inverted band: floor above ceiling, so the floor check wins below the floor; a stop caps speed at the ceiling
		load_settings(65535, 1, 65534, 0, 1);
		run_moves(60);
		// Narrow band through the divider; hold results off long enough to stall input
		load_settings(100, 300, 1000, 60000, 250000);
		run_moves(30);
		chokes_asked++;
		run_moves(80);
		// Tiny clock: reload reaches all ones, so a stop falls back to the ceiling speed
		load_settings(2, 1000, 5, 7, 1);
		run_moves(100);
		for (i = 0; i < 3; i++) begin
			lo = $urandom_range(1, 500);
			load_settings(lo, lo + $urandom_range(0, 300), $urandom_range(0, 65534),
				$urandom_range(0, 65534), $urandom_range(1, 24'hffffff));
			run_moves(110);
		end
		// Back to reset values, full throughput on both sides
		calm = 1'b1;
		load_settings(SPD_FLOOR_RST, SPD_CEIL_RST, PERIOD_SLOW_RST, PERIOD_FAST_RST,
			TICK_CLOCK_RST);
		run_moves(110);

		settle();
		if (fail_count == 0) $display("stepper_ramp_motion_controller_core_tb passed");
		else $display("stepper_ramp_motion_controller_core_tb failed");
		$finish;
	end

endmodule
